### rtl/pctd_pkg.sv
// ----------------------------------------------------------------------------
// pctd_pkg: prime counting unit constants and types
// Widths of the limit and count words and the sequencer state encoding.
// ----------------------------------------------------------------------------
package pctd_pkg;

    localparam int VALUE_BITS = 14;
    localparam int COUNT_BITS = 11;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int SQ_W       = VALUE_BITS + 2;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CAND = 5'b00010,
        S_CHK  = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

endpackage

### rtl/prime_count_trial_division_unit.sv
// ----------------------------------------------------------------------------
// prime_count_trial_division_unit: prime counting by trial division
// Counts the primes in [2, x] with a bit-serial restoring remainder unit.
// ----------------------------------------------------------------------------
// operation: candidates are stepped in turn and each trial division is bit-serial;
//   one remainder bit is produced per cycle
// throughput: one word at a time, busy stays high until the result strobe
// reset: synchronous active-low i_rst_n returns the sequencer to idle
// the result is strobed for one cycle on o_valid; the receiver cannot stall
// ----------------------------------------------------------------------------
module prime_count_trial_division_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [pctd_pkg::VALUE_BITS-1:0]    i_upper_limit,
    output logic                               o_busy,
    output logic                               o_valid,
    output logic [pctd_pkg::COUNT_BITS-1:0]    o_prime_count
);
    import pctd_pkg::*;

    t_state                  r_state, n_state;
    logic [VALUE_BITS-1:0]   r_x, n_x;
    logic [VALUE_BITS:0]     r_n, n_n;          // candidate, one bit wider than x
    logic [VALUE_BITS-1:0]   r_d, n_d;          // trial divisor
    logic [SQ_W-1:0]         r_sq, n_sq;        // divisor squared
    logic [VALUE_BITS-1:0]   r_shift, n_shift;  // candidate bits, msb first
    logic [VALUE_BITS-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]        r_bits, n_bits;
    logic [COUNT_BITS-1:0]   r_count, n_count;
    logic                    r_valid, n_valid;
    logic [COUNT_BITS-1:0]   r_result, n_result;

    logic [VALUE_BITS:0]     rem_sh;
    logic [VALUE_BITS:0]     rem_sub;
    logic [VALUE_BITS-1:0]   rem_step;
    logic [COUNT_BITS-1:0]   count_inc;

    // one restoring step of the remainder
    always_comb begin
        rem_sh  = {r_rem, r_shift[VALUE_BITS-1]};
        rem_sub = rem_sh - {1'b0, r_d};
        if (rem_sh >= {1'b0, r_d}) begin
            rem_step = rem_sub[VALUE_BITS-1:0];
        end else begin
            rem_step = rem_sh[VALUE_BITS-1:0];
        end
    end

    // saturating count
    assign count_inc = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;

    always_comb begin
        n_state  = r_state;
        n_x      = r_x;
        n_n      = r_n;
        n_d      = r_d;
        n_sq     = r_sq;
        n_shift  = r_shift;
        n_rem    = r_rem;
        n_bits   = r_bits;
        n_count  = r_count;
        n_valid  = 1'b0;
        n_result = r_result;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_x     = i_upper_limit;
                    n_n     = (VALUE_BITS+1)'(2);
                    n_count = '0;
                    n_state = S_CAND;
                end
            end
            S_CAND: begin
                priority if (r_n > {1'b0, r_x}) begin
                    n_state = S_OUT;
                end else if (r_n == (VALUE_BITS+1)'(2)) begin
                    n_count = count_inc;
                    n_n     = r_n + 1'b1;
                end else if (!r_n[0]) begin
                    n_n     = r_n + 1'b1;
                end else begin
                    // odd candidates only need odd divisors
                    n_d     = VALUE_BITS'(3);
                    n_sq    = SQ_W'(9);
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_sq > {1'b0, r_n}) begin
                    n_count = count_inc;
                    n_n     = r_n + 1'b1;
                    n_state = S_CAND;
                end else begin
                    n_shift = r_n[VALUE_BITS-1:0];
                    n_rem   = '0;
                    n_bits  = CNT_W'(VALUE_BITS);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem   = rem_step;
                n_shift = {r_shift[VALUE_BITS-2:0], 1'b0};
                n_bits  = r_bits - 1'b1;
                if (r_bits == CNT_W'(1)) begin
                    if (rem_step == '0) begin
                        n_n     = r_n + 1'b1;
                        n_state = S_CAND;
                    end else begin
                        // (d+2)^2 = d^2 + 4d + 4
                        n_sq    = r_sq + {r_d, 2'b00} + SQ_W'(4);
                        n_d     = r_d + VALUE_BITS'(2);
                        n_state = S_CHK;
                    end
                end
            end
            S_OUT: begin
                n_valid  = 1'b1;
                n_result = r_count;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x      <= n_x;
        r_n      <= n_n;
        r_d      <= n_d;
        r_sq     <= n_sq;
        r_shift  <= n_shift;
        r_rem    <= n_rem;
        r_bits   <= n_bits;
        r_count  <= n_count;
        r_result <= n_result;
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_prime_count = r_result;

endmodule

### tb/sv/tb_prime_count_trial_division_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prime_count_trial_division_unit: self-checking bench for the prime counter
// Drives upper limits through the start/busy handshake: first a table of
// corner cases, then random limits. Most random limits are small, which keeps
// the run short. Every strobed count is compared with the count of its row,
// typed in for rows marked known, else computed by trial division in the bench.
// ----------------------------------------------------------------------------
module tb_prime_count_trial_division_unit;
    import pctd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 20_000_000;
    localparam int unsigned TAIL_CYCLES = 64;
    localparam int          N_DIRECTED  = 14;
    localparam int          N_PER_PHASE = 34;

    typedef struct packed {
        logic [VALUE_BITS-1:0] limit;
        logic                  known;
        logic [COUNT_BITS-1:0] count;
    } limit_row_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] limit;
        logic [COUNT_BITS-1:0] count;
    } expected_count_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_start = 1'b0;
    logic [VALUE_BITS-1:0] i_upper_limit = '0;
    logic                  o_busy;
    logic                  o_valid;
    logic [COUNT_BITS-1:0] o_prime_count;

    expected_count_t pending_counts[$];
    bit              failed = 1'b0;
    bit              checking = 1'b0;
    int unsigned     cycle_count = 0;
    int unsigned     send_idle_pct = 0;

    // counts typed in only where they are known at a glance
    limit_row_t directed_rows [N_DIRECTED] = '{
        '{14'd0,     1'b1, 11'd0},
        '{14'd1,     1'b1, 11'd0},
        '{14'd2,     1'b1, 11'd1},
        '{14'd3,     1'b1, 11'd2},
        '{14'd4,     1'b0, 11'd0},
        '{14'd5,     1'b0, 11'd0},
        '{14'd9,     1'b0, 11'd0},
        '{14'd10,    1'b0, 11'd0},
        '{14'd25,    1'b0, 11'd0},
        '{14'd49,    1'b0, 11'd0},
        '{14'd121,   1'b0, 11'd0},
        '{14'd127,   1'b0, 11'd0},
        '{14'd1024,  1'b0, 11'd0},
        '{14'd16383, 1'b1, 11'd1900}
    };

    prime_count_trial_division_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_upper_limit (i_upper_limit),
        .o_busy        (o_busy),
        .o_valid       (o_valid),
        .o_prime_count (o_prime_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [COUNT_BITS-1:0] count_primes_upto(
        input logic [VALUE_BITS-1:0] limit
    );
        int unsigned n;
        int unsigned d;
        int unsigned total;
        bit          composite;
        total = 0;
        for (n = 2; n <= limit; n++) begin
            if (n == 2) begin
                composite = 1'b0;
            end else if (n % 2 == 0) begin
                composite = 1'b1;
            end else begin
                composite = 1'b0;
                for (d = 2; d * d <= n && !composite; d++) begin
                    if (n % d == 0)
                        composite = 1'b1;
                end
            end
            if (!composite && total < COUNT_MAX)
                total++;
        end
        return total[COUNT_BITS-1:0];
    endfunction

    // start stays high across back-to-back words, lowered only for a gap
    task automatic send_limit(input logic [VALUE_BITS-1:0] limit,
                              input logic [COUNT_BITS-1:0] count);
        while ($urandom_range(99) < send_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_upper_limit <= limit;
        forever begin
            @(posedge i_clk);
            if (o_busy === 1'b0)
                break;
        end
        pending_counts.push_back('{limit: limit, count: count});
    endtask

    function automatic logic [VALUE_BITS-1:0] random_limit();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return VALUE_BITS'($urandom_range(127));
        else if (pick < 97)
            return VALUE_BITS'($urandom_range(1023, 128));
        else
            return VALUE_BITS'($urandom_range(2047, 1024));
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        expected_count_t head;
        if (checking && o_valid === 1'b1) begin
            if (pending_counts.size() == 0) begin
                $display("%0t: unexpected count word: got %0d", $time, o_prime_count);
                failed = 1'b1;
            end else begin
                head = pending_counts.pop_front();
                if (o_prime_count !== head.count) begin
                    $display("%0t: prime count mismatch for limit %0d: expected %0d, got %0d",
                             $time, head.limit, head.count, o_prime_count);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        logic [VALUE_BITS-1:0] limit;
        int                    phase;
        int                    k;

        repeat (11) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        checking = 1'b1;
        @(posedge i_clk);

        send_idle_pct = 37;
        for (k = 0; k < N_DIRECTED; k++) begin
            if (directed_rows[k].known)
                send_limit(directed_rows[k].limit, directed_rows[k].count);
            else
                send_limit(directed_rows[k].limit,
                           count_primes_upto(directed_rows[k].limit));
        end

        // gap rate per phase: moderate, heavy, none
        for (phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 76 : 0;
            for (k = 0; k < N_PER_PHASE; k++) begin
                limit = random_limit();
                send_limit(limit, count_primes_upto(limit));
            end
        end
        i_start <= 1'b0;

        while (pending_counts.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (failed)
            $display("tb: failure");
        else
            $display("tb: success");
        $finish;
    end

endmodule
